@@ src/keyboard_matrix_with_event_queue_macros.svh @@
// ----------------------------------------------------------------------------
// Keyboard matrix assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_MATRIX_WITH_EVENT_QUEUE_MACROS_SVH
`define KEYBOARD_MATRIX_WITH_EVENT_QUEUE_MACROS_SVH

// condition holds at every edge
`define KMEQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define KMEQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define KMEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/kmeq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard matrix package
// Types and constants shared by the keyboard matrix and its event queue.
// ----------------------------------------------------------------------------
package kmeq_pkg;

	localparam int MATRIX_COLS         = 8;
	localparam int MASK_W              = 10;
	localparam int DEF_QUEUE_DEPTH     = 32;
	localparam int DEF_MATRIX_ROWS     = 10;
	localparam int CFG_DATA_W          = 4;
	localparam int CFG_INDEX_W         = 2;

	typedef enum logic [1:0] {
		REQ_DIRECT = 2'd0,
		REQ_QUEUE  = 2'd1,
		REQ_TICK   = 2'd2,
		REQ_READ   = 2'd3
	} req_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_FIRST_GEN = 2'd0,
		CFG_CK_ROW    = 2'd1,
		CFG_CK_COL    = 2'd2,
		CFG_CK_EN     = 2'd3
	} cfg_idx_t;

	// queued key event, pressed in the top bit
	typedef struct packed {
		logic       pressed;
		logic       is_on_key;
		logic [3:0] row;
		logic [2:0] col;
	} event_t;

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

endpackage

@@ src/kmeq_event_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard event FIFO
// Circular event store with a registered head entry kept ready for a pop.
// ----------------------------------------------------------------------------
module kmeq_event_fifo #(
	parameter int QUEUE_DEPTH = kmeq_pkg::DEF_QUEUE_DEPTH,
	parameter int PTR_W       = $clog2(QUEUE_DEPTH),
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  kmeq_pkg::fifo_ctl_t ctl,
	input  kmeq_pkg::event_t    wr_event,
	output kmeq_pkg::event_t    head_event,
	output logic [CNT_W-1:0]    count
);

	kmeq_pkg::event_t mem [QUEUE_DEPTH];
	kmeq_pkg::event_t head_q;
	logic [PTR_W-1:0] head_ptr_q, tail_ptr_q;
	logic [PTR_W-1:0] head_inc, tail_inc, rd_addr;
	logic [CNT_W-1:0] count_q;

	assign head_inc = (head_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ptr_q + 1'b1;
	assign tail_inc = (tail_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ptr_q + 1'b1;
	assign rd_addr  = ctl.pop ? head_inc : head_ptr_q;

	// write-through on the head entry when the queue is empty
	always_ff @(posedge clk) begin
		if (ctl.push)
			mem[tail_ptr_q] <= wr_event;
		if (ctl.push && (tail_ptr_q == rd_addr))
			head_q <= wr_event;
		else
			head_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			count_q    <= '0;
		end else begin
			if (ctl.push)
				tail_ptr_q <= tail_inc;
			if (ctl.pop)
				head_ptr_q <= head_inc;
			if (ctl.push && !ctl.pop)
				count_q <= count_q + 1'b1;
			else if (ctl.pop && !ctl.push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head_event = head_q;
	assign count      = count_q;

endmodule

@@ src/keyboard_matrix_with_event_queue.sv @@
`timescale 1ns / 1ps
// The input register holds a request and the output register its result with m_tvalid.
// Throughput: one request per cycle unless m_tready stalls the output, set by the single
// register-to-register pass through the matrix update, the 80-bit column OR and the FIFO
// head access. Reset: arst_n clears matrix, count, flags, pointers and config (counted
// key enable set to 1); FIFO contents are left unwritten, no clearing pass.
// ----------------------------------------------------------------------------
// Keyboard matrix with event queue
// Key matrix, ON key and interrupt flags fed by direct and queued key events.
// ----------------------------------------------------------------------------
`include "keyboard_matrix_with_event_queue_macros.svh"

module keyboard_matrix_with_event_queue #(
	parameter int QUEUE_DEPTH = kmeq_pkg::DEF_QUEUE_DEPTH,
	parameter int MATRIX_ROWS = kmeq_pkg::DEF_MATRIX_ROWS,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
	parameter int OUT_W       = ((12 + CNT_W + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// key_row[3:0], key_col[6:4], is_on_key[7], pressed[8],
	// row_select_mask[18:9], int_ctrl_bit2[19], int_ctrl_bit1[20], zero pad
	input  logic [23:0]                    s_tdata,
	// req_type[1:0]
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// column_data[7:0], irq_key[8], irq_on[9], on_key_level[10],
	// queue_dropped[11], queue_count[12+:CNT_W], zero pad
	output logic [OUT_W-1:0]               m_tdata,
	input  logic                           cfg_we,
	input  logic [kmeq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [kmeq_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int BIT_IRQ_ON = 9;
	localparam int BIT_ON_LVL = 10;
	localparam int BIT_DROP   = 11;
	localparam int BIT_CNT    = 12;

	// config
	logic       first_gen_q;
	logic [3:0] ck_row_q;
	logic [2:0] ck_col_q;
	logic       ck_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_gen_q <= 1'b0;
			ck_row_q    <= '0;
			ck_col_q    <= '0;
			ck_en_q     <= 1'b1;
		end else if (cfg_we) begin
			unique case (kmeq_pkg::cfg_idx_t'(cfg_index))
				kmeq_pkg::CFG_FIRST_GEN: first_gen_q <= cfg_data[0];
				kmeq_pkg::CFG_CK_ROW:    ck_row_q    <= cfg_data[3:0];
				kmeq_pkg::CFG_CK_COL:    ck_col_q    <= cfg_data[2:0];
				kmeq_pkg::CFG_CK_EN:     ck_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic                        valid_s1;
	kmeq_pkg::req_t              req_s1;
	kmeq_pkg::event_t            ev_s1;
	logic [kmeq_pkg::MASK_W-1:0] mask_s1;
	logic                        b2_s1, b1_s1;
	logic                        out_valid_q;
	logic [OUT_W-1:0]            out_data_q;
	logic                        advance, proc;

	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign proc     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1  <= kmeq_pkg::req_t'(s_tuser);
			ev_s1   <= '{pressed: s_tdata[8], is_on_key: s_tdata[7],
			             row: s_tdata[3:0], col: s_tdata[6:4]};
			mask_s1 <= s_tdata[18:9];
			b2_s1   <= s_tdata[19];
			b1_s1   <= s_tdata[20];
		end
	end

	// state
	logic [7:0] matrix_q [MATRIX_ROWS];
	logic [7:0] matrix_d [MATRIX_ROWS];
	logic [3:0] ck_cnt_q, ck_cnt_d;
	logic       key_flag_q, key_flag_d;
	logic       on_flag_q, on_flag_d;
	logic       on_held_q, on_held_d;

	kmeq_pkg::fifo_ctl_t fifo_ctl;
	kmeq_pkg::event_t    head_event;
	logic [CNT_W-1:0]    fifo_count;
	logic                fifo_full, fifo_empty;

	assign fifo_full  = (fifo_count == CNT_W'(QUEUE_DEPTH));
	assign fifo_empty = (fifo_count == '0);

	kmeq_event_fifo #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       (CNT_W)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (fifo_ctl),
		.wr_event   (ev_s1),
		.head_event (head_event),
		.count      (fifo_count)
	);

	kmeq_pkg::event_t ev;
	logic             apply_en;
	logic             irq_key, irq_on, dropped;
	logic [7:0]       col_acc, row_bits;
	logic [CNT_W-1:0] count_after;
	logic [OUT_W-1:0] result;

	always_comb begin
		fifo_ctl.push = proc && (req_s1 == kmeq_pkg::REQ_QUEUE) && !fifo_full;
		fifo_ctl.pop  = proc && (req_s1 == kmeq_pkg::REQ_TICK) && !fifo_empty;
		dropped       = (req_s1 == kmeq_pkg::REQ_QUEUE) && fifo_full;
		ev            = (req_s1 == kmeq_pkg::REQ_TICK) ? head_event : ev_s1;
		apply_en      = proc && ((req_s1 == kmeq_pkg::REQ_DIRECT) || fifo_ctl.pop);

		matrix_d   = matrix_q;
		ck_cnt_d   = ck_cnt_q;
		key_flag_d = key_flag_q;
		on_flag_d  = on_flag_q;
		on_held_d  = on_held_q;

		if (apply_en) begin
			if (ev.is_on_key) begin
				on_held_d = ev.pressed;
				if (ev.pressed)
					on_flag_d = 1'b1;
			end else if (int'(ev.row) < MATRIX_ROWS) begin
				if (ev.pressed)
					key_flag_d = 1'b1;
				if (ck_en_q && ev.row == ck_row_q && ev.col == ck_col_q) begin
					ck_cnt_d = ev.pressed ? ck_cnt_q + 1'b1 : ck_cnt_q - 1'b1;
				end else begin
					for (int r = 0; r < MATRIX_ROWS; r++) begin
						if (ev.row == 4'(r))
							matrix_d[r][~ev.col] = ev.pressed;
					end
				end
			end
		end

		irq_key = 1'b0;
		irq_on  = 1'b0;
		if (proc && req_s1 == kmeq_pkg::REQ_TICK) begin
			if (key_flag_d) begin
				irq_key    = first_gen_q || !(b2_s1 && !b1_s1);
				key_flag_d = 1'b0;
			end
			if (on_flag_d && on_held_d) begin
				irq_on    = 1'b1;
				on_flag_d = 1'b0;
			end
		end
	end

	// column read
	always_comb begin
		col_acc = '0;
		for (int r = 0; r < MATRIX_ROWS; r++) begin
			row_bits = matrix_q[r];
			if (ck_en_q && ck_row_q == 4'(r))
				row_bits[~ck_col_q] = ck_cnt_q[0];
			if (r >= kmeq_pkg::MASK_W || !mask_s1[r % kmeq_pkg::MASK_W])
				col_acc = col_acc | row_bits;
		end
	end

	always_comb begin
		if (fifo_ctl.push)
			count_after = fifo_count + 1'b1;
		else if (fifo_ctl.pop)
			count_after = fifo_count - 1'b1;
		else
			count_after = fifo_count;
		result = OUT_W'({count_after, dropped, on_held_d, irq_on, irq_key,
		                 (req_s1 == kmeq_pkg::REQ_READ) ? ~col_acc : 8'h00});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MATRIX_ROWS; r++)
				matrix_q[r] <= '0;
			ck_cnt_q    <= '0;
			key_flag_q  <= 1'b0;
			on_flag_q   <= 1'b0;
			on_held_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			matrix_q   <= matrix_d;
			ck_cnt_q   <= ck_cnt_d;
			key_flag_q <= key_flag_d;
			on_flag_q  <= on_flag_d;
			on_held_q  <= on_held_d;
			if (proc)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc)
			out_data_q <= result;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`KMEQ_ASSERT_ALWAYS(a_count_max, fifo_count <= CNT_W'(QUEUE_DEPTH), "FIFO count over depth")
	`KMEQ_ASSERT_IMPL(a_irq_on_held, m_tvalid && m_tdata[BIT_IRQ_ON], m_tdata[BIT_ON_LVL], "ON irq without ON held")
	`KMEQ_ASSERT_IMPL(a_drop_full, m_tvalid && m_tdata[BIT_DROP], m_tdata[BIT_CNT +: CNT_W] == CNT_W'(QUEUE_DEPTH), "drop with FIFO not full")
	`KMEQ_ASSERT_NEXT(a_pop_dec, fifo_ctl.pop, fifo_count == $past(fifo_count) - 1'b1, "pop did not drain one entry")
	`KMEQ_ASSERT_IMPL(a_no_push_pop, fifo_ctl.push, !fifo_ctl.pop && !fifo_full, "push on full or with pop")

endmodule
